FILE: rtl/helmert_seven_parameter_transform_defines.svh
// Assertion macros for the Helmert transform block.
// Included by the top level; no other dependencies.
`ifndef HELMERT_SEVEN_PARAMETER_TRANSFORM_DEFINES_SVH
`define HELMERT_SEVEN_PARAMETER_TRANSFORM_DEFINES_SVH
`ifndef SYNTHESIS
`define HSPT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define HSPT_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) ante |=> cons) \
      else $error(msg);
`else
`define HSPT_ASSERT(name, prop, msg)
`define HSPT_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

FILE: rtl/hspt_pkg.sv
// Shared constants and types for the Helmert transform block.
// No dependencies; used by every module of the block.
`default_nettype none

package hspt_pkg;

   localparam int COORD_W       = 34;
   localparam int SHIFT_W       = 21;
   localparam int ANGLE_W       = 29;   // rotation and scale words
   localparam int CSR_DATA_W    = 29;
   localparam int CSR_INDEX_W   = 3;
   localparam int FRAC_BITS_DEF = 40;
   localparam int SPLIT_BITS    = 20;   // low slice of the scale multiplicand
   localparam int TDATA_W       = ((3 * COORD_W + 7) / 8) * 8;

   // pipeline stage numbers
   localparam int ST_A   = 0;   // operand prep, inverse translation
   localparam int ST_MUL = 1;   // rotation products
   localparam int ST_ROT = 2;   // rotation sums
   localparam int ST_V   = 3;   // rounded rotation added to point
   localparam int ST_PP  = 4;   // scale partial products
   localparam int ST_SCL = 5;   // rounded scale term
   localparam int ST_OUT = 6;   // final sum, saturation, output register
   localparam int STAGES = 7;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SHIFT_X       = 3'd0,
      REG_SHIFT_Y       = 3'd1,
      REG_SHIFT_Z       = 3'd2,
      REG_ROT_X         = 3'd3,
      REG_ROT_Y         = 3'd4,
      REG_ROT_Z         = 3'd5,
      REG_SCALE_DEV     = 3'd6,
      REG_INV_SCALE_DEV = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] shift_x;
      logic [SHIFT_W-1:0] shift_y;
      logic [SHIFT_W-1:0] shift_z;
      logic [ANGLE_W-1:0] rot_x;
      logic [ANGLE_W-1:0] rot_y;
      logic [ANGLE_W-1:0] rot_z;
      logic [ANGLE_W-1:0] scale_dev;
      logic [ANGLE_W-1:0] inv_scale_dev;
   } cfg_type;

   typedef struct packed {
      logic [STAGES-1:0] load;   // per-stage register enable
   } pipe_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/helmert_seven_parameter_transform.sv
// Top level of the seven-parameter Helmert (Bursa-Wolf) transform block.
// Depends on hspt_pkg, hspt_datapath and the assertion macro header.
`default_nettype none

// Transforms one geocentric point (mm) per beat. tuser selects the direction:
// 0 = forward (small-angle rotation, times 1+scale_dev, plus translation),
// 1 = inverse (minus translation, transposed rotation, times 1+inv_scale_dev).
// Angles and scale words are in units of 2^-FRAC_BITS; software does the
// arcsecond/ppm conversion and computes the inverse scale. Intermediate
// products are rounded half up at the binary point. Each output coordinate
// clamps to 34-bit signed and rsp_tuser flags any clamp.
// Pipeline: a point passes from req beat to rsp beat through the seven
// register stages (operand prep, rotation multipliers, rotation sum, round and
// add, scale partial products, scale recombine, final sum and clamp, which is
// also the output register). A new point is accepted every cycle; a stalled
// rsp side fills the bubbles first and then deasserts req_tready, nothing is
// dropped or repeated. CSR map (index: register): 0 shift_x, 1 shift_y,
// 2 shift_z (21 bits), 3 rot_about_x, 4 rot_about_y, 5 rot_about_z,
// 6 scale_dev, 7 inv_scale_dev (29 bits); all signed, reset to zero. The user
// must write them only while no point is in flight; the block does not enforce it.

`include "helmert_seven_parameter_transform_defines.svh"

module helmert_seven_parameter_transform #(
   parameter int FRAC_BITS = hspt_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hspt_pkg::TDATA_W-1:0]        req_tdata,   // x_in, y_in, z_in, zero pad
   input  logic                                req_tuser,   // func
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hspt_pkg::TDATA_W-1:0]        rsp_tdata,   // x_out, y_out, z_out, zero pad
   output logic                                rsp_tuser,   // overflow
   // config writes
   input  logic                                csr_we,
   input  logic [hspt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hspt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW = hspt_pkg::COORD_W;
   localparam int NS = hspt_pkg::STAGES;

   hspt_pkg::cfg_type      cfg_ff, cfg_in;
   hspt_pkg::pipe_ctl_type ctl;

   logic [NS-1:0] vld_ff, vld_in, vld_prev, load;
   logic          req_beat, rsp_beat;

   logic signed [CW-1:0] res_x, res_y, res_z;
   logic                 res_ovf, res_at_rail;

   // ---------------------------------------------------------------- CSRs
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (hspt_pkg::csr_index_type'(csr_index))
            hspt_pkg::REG_SHIFT_X:       cfg_in.shift_x = csr_wdata[hspt_pkg::SHIFT_W-1:0];
            hspt_pkg::REG_SHIFT_Y:       cfg_in.shift_y = csr_wdata[hspt_pkg::SHIFT_W-1:0];
            hspt_pkg::REG_SHIFT_Z:       cfg_in.shift_z = csr_wdata[hspt_pkg::SHIFT_W-1:0];
            hspt_pkg::REG_ROT_X:         cfg_in.rot_x = csr_wdata[hspt_pkg::ANGLE_W-1:0];
            hspt_pkg::REG_ROT_Y:         cfg_in.rot_y = csr_wdata[hspt_pkg::ANGLE_W-1:0];
            hspt_pkg::REG_ROT_Z:         cfg_in.rot_z = csr_wdata[hspt_pkg::ANGLE_W-1:0];
            hspt_pkg::REG_SCALE_DEV:     cfg_in.scale_dev = csr_wdata[hspt_pkg::ANGLE_W-1:0];
            hspt_pkg::REG_INV_SCALE_DEV: cfg_in.inv_scale_dev = csr_wdata[hspt_pkg::ANGLE_W-1:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ------------------------------------------------------- valid chain
   // A stage loads when it is empty or the stage after it moves on, so
   // bubbles collapse under backpressure.
   assign vld_prev = {vld_ff[NS-2:0], req_tvalid};

   always_comb begin
      load[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
      for (int k = 0; k < NS; k++) begin
         vld_in[k] = load[k] ? vld_prev[k] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign ctl.load   = load;
   assign req_tready = load[hspt_pkg::ST_A];
   assign rsp_tvalid = vld_ff[hspt_pkg::ST_OUT];
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_beat   = rsp_tvalid && rsp_tready;

   // ---------------------------------------------------------- datapath
   hspt_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock   (clock),
      .ctl     (ctl),
      .cfg     (cfg_ff),
      .in_func (req_tuser),
      .in_x    ($signed(req_tdata[CW-1:0])),
      .in_y    ($signed(req_tdata[2*CW-1:CW])),
      .in_z    ($signed(req_tdata[3*CW-1:2*CW])),
      .out_x   (res_x),
      .out_y   (res_y),
      .out_z   (res_z),
      .out_ovf (res_ovf)
   );

   assign rsp_tdata = {{(hspt_pkg::TDATA_W-3*CW){1'b0}}, res_z, res_y, res_x};
   assign rsp_tuser = res_ovf;

   assign res_at_rail = (res_x == hspt_pkg::COORD_MAX) || (res_x == hspt_pkg::COORD_MIN) ||
                        (res_y == hspt_pkg::COORD_MAX) || (res_y == hspt_pkg::COORD_MIN) ||
                        (res_z == hspt_pkg::COORD_MAX) || (res_z == hspt_pkg::COORD_MIN);

   // -------------------------------------------------------- assertions
   // points in flight track input and output beats exactly
   `HSPT_ASSERT_NEXT(a_occupancy, 1'b1, $countones(vld_ff) == $past($countones(vld_ff)) + $past(req_beat) - $past(rsp_beat), "pipeline occupancy lost or gained a point")
   // input stalls only with a full pipe and a stalled output
   `HSPT_ASSERT(a_stall_full, !req_tready |-> (&vld_ff) && !rsp_tready, "input stalled with room in the pipeline")
   // a saturation flag comes with a clamped coordinate
   `HSPT_ASSERT(a_ovf_rail, rsp_tvalid && res_ovf |-> res_at_rail, "overflow flagged without a clamped coordinate")

endmodule

`default_nettype wire

FILE: rtl/hspt_scale_round.sv
// Two-stage multiply of one coordinate by a scale word, rounded at the binary point.
// Depends on hspt_pkg.
`default_nettype none

module hspt_scale_round #(
   parameter int FRAC_BITS = hspt_pkg::FRAC_BITS_DEF,
   parameter int V_W       = 36
) (
   input  logic                                            clock,
   input  hspt_pkg::pipe_ctl_type                          ctl,
   input  logic signed [V_W-1:0]                           v,
   input  logic signed [hspt_pkg::ANGLE_W-1:0]             coef,
   output logic signed [V_W+hspt_pkg::ANGLE_W-FRAC_BITS:0] scl
);

   localparam int S_W  = hspt_pkg::SPLIT_BITS;
   localparam int HI_W = V_W - S_W;
   localparam int HP_W = HI_W + hspt_pkg::ANGLE_W;
   localparam int LP_W = S_W + 1 + hspt_pkg::ANGLE_W;
   localparam int SP_W = V_W + hspt_pkg::ANGLE_W + 1;
   localparam int SC_W = SP_W - FRAC_BITS;
   localparam logic [SP_W-1:0] HALF = {{(SP_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

   logic signed [HI_W-1:0] hi;
   logic signed [S_W:0]    lo;
   logic signed [HP_W-1:0] hp_in, hp_ff;
   logic signed [LP_W-1:0] lp_in, lp_ff;
   logic        [SP_W-1:0] sum;
   logic signed [SC_W-1:0] scl_in, scl_ff;

   // stage 4: split multiplicand, two narrow products
   always_comb begin
      hi    = v[V_W-1:S_W];
      lo    = $signed({1'b0, v[S_W-1:0]});
      hp_in = HP_W'(hi) * HP_W'(coef);
      lp_in = LP_W'(lo) * LP_W'(coef);
   end

   // stage 5: recombine, round half up, drop fraction
   always_comb begin
      sum    = (SP_W'(hp_ff) << S_W) + SP_W'(lp_ff) + HALF;
      scl_in = $signed(sum[SP_W-1:FRAC_BITS]);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[hspt_pkg::ST_PP]) begin
         hp_ff <= hp_in;
         lp_ff <= lp_in;
      end
      if (ctl.load[hspt_pkg::ST_SCL]) begin
         scl_ff <= scl_in;
      end
   end

   assign scl = scl_ff;

endmodule

`default_nettype wire

FILE: rtl/hspt_datapath.sv
// Seven-stage arithmetic pipeline of the Helmert transform, one point per beat.
// Depends on hspt_pkg and hspt_scale_round.
`default_nettype none

module hspt_datapath #(
   parameter int FRAC_BITS = hspt_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  hspt_pkg::pipe_ctl_type               ctl,
   input  hspt_pkg::cfg_type                    cfg,
   input  logic                                 in_func,
   input  logic signed [hspt_pkg::COORD_W-1:0]  in_x,
   input  logic signed [hspt_pkg::COORD_W-1:0]  in_y,
   input  logic signed [hspt_pkg::COORD_W-1:0]  in_z,
   output logic signed [hspt_pkg::COORD_W-1:0]  out_x,
   output logic signed [hspt_pkg::COORD_W-1:0]  out_y,
   output logic signed [hspt_pkg::COORD_W-1:0]  out_z,
   output logic                                 out_ovf
);

   localparam int CW   = hspt_pkg::COORD_W;
   localparam int AW   = hspt_pkg::ANGLE_W;
   localparam int NS   = hspt_pkg::STAGES;
   localparam int A_W  = CW + 1;
   localparam int P_W  = A_W + AW;
   localparam int R_W  = P_W + 1;
   localparam int RS_W = R_W + 1 - FRAC_BITS;
   localparam int V_W  = ((A_W > RS_W) ? A_W : RS_W) + 1;
   localparam int SC_W = V_W + AW + 1 - FRAC_BITS;
   localparam int W_W  = ((V_W > SC_W) ? V_W : SC_W) + 2;
   localparam logic [R_W:0] HALF = {{(R_W+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

   logic signed [AW-1:0]                  om, ph, ka, fwd_scale, inv_scale, coef;
   logic signed [hspt_pkg::SHIFT_W-1:0]   shift   [3];
   logic signed [CW-1:0]                  coord   [3];

   logic [NS-1:0] func_ff, func_prev;

   logic signed [A_W-1:0] a0_in [3], a0_ff [3], a1_ff [3], a2_ff [3];
   logic signed [P_W-1:0] prod_in [6], prod_ff [6];
   logic signed [R_W-1:0] r_in [3], r_ff [3];
   logic        [R_W:0]   rr [3];
   logic signed [V_W-1:0] v_in [3], v3_ff [3], v4_ff [3], v5_ff [3];
   logic signed [SC_W-1:0] scl [3];
   logic signed [W_W-1:0] w [3];
   logic signed [CW-1:0]  out_in [3], out_ff [3];
   logic [2:0]            sat_in;
   logic                  ovf_ff;

   assign om        = $signed(cfg.rot_x);
   assign ph        = $signed(cfg.rot_y);
   assign ka        = $signed(cfg.rot_z);
   assign fwd_scale = $signed(cfg.scale_dev);
   assign inv_scale = $signed(cfg.inv_scale_dev);
   assign shift[0]  = $signed(cfg.shift_x);
   assign shift[1]  = $signed(cfg.shift_y);
   assign shift[2]  = $signed(cfg.shift_z);
   assign coord[0]  = in_x;
   assign coord[1]  = in_y;
   assign coord[2]  = in_z;

   assign func_prev = {func_ff[NS-2:0], in_func};

   // stage 0: inverse removes translation up front
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (in_func) begin
            a0_in[i] = A_W'(coord[i]) - A_W'(shift[i]);
         end else begin
            a0_in[i] = A_W'(coord[i]);
         end
      end
   end

   // stage 1: products in pairs, positive term of the forward form first
   always_comb begin
      prod_in[0] = P_W'(ka) * P_W'(a0_ff[1]);
      prod_in[1] = P_W'(ph) * P_W'(a0_ff[2]);
      prod_in[2] = P_W'(om) * P_W'(a0_ff[2]);
      prod_in[3] = P_W'(ka) * P_W'(a0_ff[0]);
      prod_in[4] = P_W'(ph) * P_W'(a0_ff[0]);
      prod_in[5] = P_W'(om) * P_W'(a0_ff[1]);
   end

   // stage 2: transposed rotation is the negated difference
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (func_ff[hspt_pkg::ST_MUL]) begin
            r_in[i] = R_W'(prod_ff[2*i+1]) - R_W'(prod_ff[2*i]);
         end else begin
            r_in[i] = R_W'(prod_ff[2*i]) - R_W'(prod_ff[2*i+1]);
         end
      end
   end

   // stage 3: round half up and add to the point
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rr[i]   = (R_W+1)'(r_ff[i]) + HALF;
         v_in[i] = V_W'(a2_ff[i]) + V_W'($signed(rr[i][R_W:FRAC_BITS]));
      end
   end

   assign coef = func_ff[hspt_pkg::ST_V] ? inv_scale : fwd_scale;

   // stages 4 and 5
   for (genvar g = 0; g < 3; g++) begin : g_scale
      hspt_scale_round #(
         .FRAC_BITS (FRAC_BITS),
         .V_W       (V_W)
      ) u_scale (
         .clock (clock),
         .ctl   (ctl),
         .v     (v3_ff[g]),
         .coef  (coef),
         .scl   (scl[g])
      );
   end

   // stage 6: forward adds translation last, then clamp
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (func_ff[hspt_pkg::ST_SCL]) begin
            w[i] = W_W'(v5_ff[i]) + W_W'(scl[i]);
         end else begin
            w[i] = W_W'(v5_ff[i]) + W_W'(scl[i]) + W_W'(shift[i]);
         end
         if (w[i] > W_W'(hspt_pkg::COORD_MAX)) begin
            out_in[i] = hspt_pkg::COORD_MAX;
            sat_in[i] = 1'b1;
         end else if (w[i] < W_W'(hspt_pkg::COORD_MIN)) begin
            out_in[i] = hspt_pkg::COORD_MIN;
            sat_in[i] = 1'b1;
         end else begin
            out_in[i] = w[i][CW-1:0];
            sat_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (ctl.load[k]) begin
            func_ff[k] <= func_prev[k];
         end
      end
      if (ctl.load[hspt_pkg::ST_A]) begin
         a0_ff <= a0_in;
      end
      if (ctl.load[hspt_pkg::ST_MUL]) begin
         prod_ff <= prod_in;
         a1_ff   <= a0_ff;
      end
      if (ctl.load[hspt_pkg::ST_ROT]) begin
         r_ff  <= r_in;
         a2_ff <= a1_ff;
      end
      if (ctl.load[hspt_pkg::ST_V]) begin
         v3_ff <= v_in;
      end
      if (ctl.load[hspt_pkg::ST_PP]) begin
         v4_ff <= v3_ff;
      end
      if (ctl.load[hspt_pkg::ST_SCL]) begin
         v5_ff <= v4_ff;
      end
      if (ctl.load[hspt_pkg::ST_OUT]) begin
         out_ff <= out_in;
         ovf_ff <= |sat_in;
      end
   end

   assign out_x   = out_ff[0];
   assign out_y   = out_ff[1];
   assign out_z   = out_ff[2];
   assign out_ovf = ovf_ff;

endmodule

`default_nettype wire

FILE: bench/tb_helmert_seven_parameter_transform.sv
// Self-checking testbench for the seven-parameter Helmert transform block.
// Needs hspt_pkg and the block's RTL; drives req/rsp streams and CSR writes,
// predicts each point in exact wide integer arithmetic and checks every result.

module tb_helmert_seven_parameter_transform;
   timeunit 1ns;
   timeprecision 1ps;

   import hspt_pkg::*;

   localparam int FRAC_BITS    = FRAC_BITS_DEF;
   localparam int PAD_W        = TDATA_W - 3 * COORD_W;
   localparam int RESET_CYCLES = 7;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int MAX_REPORTS  = 40;
   localparam int RANDOM_PHASES    = 12;
   localparam int POINTS_PER_PHASE = 162;
   localparam int HOLDOFF_CYCLES   = 80;

   // register value styles
   localparam int PICK_ZERO  = 0;
   localparam int PICK_MAX   = 1;
   localparam int PICK_MIN   = 2;
   localparam int PICK_SMALL = 3;
   localparam int PICK_FULL  = 4;

   // coordinate styles for random points
   localparam int COORD_EARTH  = 0;   // about +-2^32 mm, the realistic range
   localparam int COORD_FULL   = 1;
   localparam int COORD_TOP    = 2;   // just under the positive clamp
   localparam int COORD_BOTTOM = 3;   // just over the negative clamp
   localparam int COORD_TINY   = 4;

   // direction select carried on req_tuser
   typedef enum logic {
      FORWARD = 1'b0,
      INVERSE = 1'b1
   } direction_type;

   // wide enough that no product or sum of the transform can overflow
   typedef logic signed [127:0] acc_type;

   typedef struct packed {
      logic               overflow;
      logic [COORD_W-1:0] z;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } point_result_type;

   // Holds the CSR shadow and the queue of points still owed by the block.
   class point_scoreboard;
      acc_type          shift [3];
      acc_type          rot_x, rot_y, rot_z;
      acc_type          scale_fwd, scale_inv;
      point_result_type expected_points [$];
      int               mismatches;

      function new();
         foreach (shift[i]) shift[i] = 0;
         rot_x = 0;
         rot_y = 0;
         rot_z = 0;
         scale_fwd = 0;
         scale_inv = 0;
         mismatches = 0;
      endfunction

      // only the low bits of each register's width count, read as signed
      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_SHIFT_X:       shift[0]  = $signed(val[SHIFT_W-1:0]);
            REG_SHIFT_Y:       shift[1]  = $signed(val[SHIFT_W-1:0]);
            REG_SHIFT_Z:       shift[2]  = $signed(val[SHIFT_W-1:0]);
            REG_ROT_X:         rot_x     = $signed(val[ANGLE_W-1:0]);
            REG_ROT_Y:         rot_y     = $signed(val[ANGLE_W-1:0]);
            REG_ROT_Z:         rot_z     = $signed(val[ANGLE_W-1:0]);
            REG_SCALE_DEV:     scale_fwd = $signed(val[ANGLE_W-1:0]);
            REG_INV_SCALE_DEV: scale_inv = $signed(val[ANGLE_W-1:0]);
            default: ;
         endcase
      endfunction

      // drop FRAC_BITS fraction bits, ties go toward plus infinity
      function acc_type round_frac(acc_type a);
         return (a + (acc_type'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      endfunction

      function point_result_type transform_point(direction_type dir,
                                                 logic [COORD_W-1:0] x, y, z);
         acc_type            a [3];
         acc_type            r [3];
         acc_type            v, w, factor;
         logic [COORD_W-1:0] coord [3];
         point_result_type   res;
         a[0] = $signed(x);
         a[1] = $signed(y);
         a[2] = $signed(z);
         res.overflow = 1'b0;
         if (dir == INVERSE) begin
            // translation comes off first, then the transposed rotation
            for (int i = 0; i < 3; i++) a[i] = a[i] - shift[i];
            r[0] = rot_y * a[2] - rot_z * a[1];
            r[1] = rot_z * a[0] - rot_x * a[2];
            r[2] = rot_x * a[1] - rot_y * a[0];
            factor = scale_inv;
         end else begin
            r[0] = rot_z * a[1] - rot_y * a[2];
            r[1] = rot_x * a[2] - rot_z * a[0];
            r[2] = rot_y * a[0] - rot_x * a[1];
            factor = scale_fwd;
         end
         for (int i = 0; i < 3; i++) begin
            v = a[i] + round_frac(r[i]);
            w = v + round_frac(v * factor);
            if (dir == FORWARD) w = w + shift[i];
            if (w > COORD_MAX) begin
               w = COORD_MAX;
               res.overflow = 1'b1;
            end else if (w < COORD_MIN) begin
               w = COORD_MIN;
               res.overflow = 1'b1;
            end
            coord[i] = w[COORD_W-1:0];
         end
         res.x = coord[0];
         res.y = coord[1];
         res.z = coord[2];
         return res;
      endfunction

      function void note_point(direction_type dir, logic [COORD_W-1:0] x, y, z);
         expected_points.push_back(transform_point(dir, x, y, z));
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0d actual %0d",
                        $time, name, want, got);
         end
      endfunction

      function void check_point(logic [TDATA_W-1:0] data, logic flag);
         point_result_type want;
         if (expected_points.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected result beat, expected none actual %h/%b",
                        $time, data, flag);
            return;
         end
         want = expected_points.pop_front();
         compare_field("x_out", $signed(want.x), $signed(data[COORD_W-1:0]));
         compare_field("y_out", $signed(want.y), $signed(data[2*COORD_W-1:COORD_W]));
         compare_field("z_out", $signed(want.z), $signed(data[3*COORD_W-1:2*COORD_W]));
         compare_field("overflow", want.overflow, flag);
         compare_field("tdata pad", 0, data[TDATA_W-1:3*COORD_W]);
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // DUT signals, all at known values from time zero
   // ---------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [TDATA_W-1:0]     req_tdata  = '0;   // x_in, y_in, z_in, zero pad
   logic                   req_tuser  = 1'b0; // func
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TDATA_W-1:0]     rsp_tdata;         // x_out, y_out, z_out, zero pad
   logic                   rsp_tuser;         // overflow
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   point_scoreboard        board;
   logic [CSR_DATA_W-1:0]  settings [1 << CSR_INDEX_W];
   int                     idle_pct     = 0;  // sender gap odds per cycle, percent
   int                     stall_pct    = 0;  // receiver stall odds per cycle, percent
   int                     hold_request = 0;  // main thread asks for a long rsp holdoff
   int                     hold_left    = 0;
   int                     cycle_count  = 0;

   helmert_seven_parameter_transform #(
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case the block wedges or drops a beat.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("helmert_seven_parameter_transform regression: fail");
         $finish;
      end
   end

   // Result side: check every accepted beat, then pick next cycle's tready.
   // A holdoff request keeps tready low for a long run so the pipe fills and
   // the block has to push back on req_tready.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) board.check_point(rsp_tdata, rsp_tuser);
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Offer one point, with random idle cycles ahead of it; returns after the
   // beat is taken. Pad bits above z_in get junk, the block must ignore them.
   task automatic send_point(direction_type dir, logic [COORD_W-1:0] x, y, z);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= dir;
      req_tdata  <= {PAD_W'($urandom), z, y, x};
      do @(posedge clock); while (!req_tready);
      board.note_point(dir, x, y, z);
   endtask

   // Drop the offer, wait for every owed result and then for the pipeline to
   // drain, so that nothing is in flight when the CSRs change.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (STAGES + 2) @(posedge clock);
   endtask

   // Register value of a given width; bits above the width carry junk.
   function automatic logic [CSR_DATA_W-1:0] pick_reg_value(int width, int choice);
      longint                v;
      logic [CSR_DATA_W-1:0] mask;
      mask = CSR_DATA_W'((64'd1 << width) - 1);
      case (choice)
         PICK_ZERO:  v = 0;
         PICK_MAX:   v = (64'sd1 <<< (width - 1)) - 1;
         PICK_MIN:   v = -(64'sd1 <<< (width - 1));
         PICK_SMALL: v = longint'($urandom_range(0, 2000)) - 1000;
         default:    v = $urandom;
      endcase
      return (CSR_DATA_W'($urandom) & ~mask) | (CSR_DATA_W'(v) & mask);
   endfunction

   // choice < 0 draws a style per register
   task automatic fill_settings(int choice);
      csr_index_type idx;
      idx = idx.first();
      do begin
         settings[idx] = pick_reg_value(idx <= REG_SHIFT_Z ? SHIFT_W : ANGLE_W,
                                        choice < 0 ? $urandom_range(PICK_ZERO, PICK_FULL + 1)
                                                   : choice);
         idx = idx.next();
      end while (idx != idx.first());
   endtask

   // One CSR write per cycle, all eight back to back; the shadow follows.
   task automatic load_settings();
      csr_index_type idx;
      idx = idx.first();
      do begin
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= settings[idx];
         @(posedge clock);
         board.set_reg(idx, settings[idx]);
         idx = idx.next();
      end while (idx != idx.first());
      csr_we <= 1'b0;
   endtask

   function automatic logic [COORD_W-1:0] pick_coord(int kind);
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case (kind)
         COORD_EARTH:  pick_coord = COORD_W'($signed(raw[32:0]));
         COORD_TOP:    pick_coord = COORD_MAX - raw[9:0];
         COORD_BOTTOM: pick_coord = COORD_MIN + raw[9:0];
         COORD_TINY:   pick_coord = COORD_W'($signed(raw[11:0]));
         default:      pick_coord = raw[COORD_W-1:0];
      endcase
   endfunction

   // Mostly realistic points; some full-range and some hugging the clamps.
   task automatic send_random_point();
      logic [COORD_W-1:0] c [3];
      int                 style;
      style = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++)
         c[i] = pick_coord(style < 6 ? COORD_EARTH :
                           style < 8 ? COORD_FULL  : $urandom_range(COORD_EARTH, COORD_TINY));
      send_point(direction_type'($urandom_range(0, 1)), c[0], c[1], c[2]);
   endtask

   // Clamp corners both ways plus a real ground station.
   task automatic send_landmarks();
      send_point(FORWARD, COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(FORWARD, COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(INVERSE, COORD_MAX, COORD_MIN, COORD_MAX);
      send_point(INVERSE, COORD_MIN, COORD_MAX, COORD_MIN);
      send_point(FORWARD, 34'sd3980000000, 34'sd102000000, 34'sd4966000000);
      send_point(INVERSE, 34'sd3980000000, 34'sd102000000, 34'sd4966000000);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Registers at reset value: both directions must be the identity.
      send_point(FORWARD, '0, '0, '0);
      send_point(FORWARD, COORD_MAX, COORD_MIN, '1);
      send_point(INVERSE, COORD_MIN, COORD_MAX, 34'sd1);

      // Rounding ties: kappa and both scales at the most negative word make
      // +-2048 land exactly on a half LSB in the rotation and scale terms.
      settle_block();
      fill_settings(PICK_ZERO);
      settings[REG_ROT_Z]         = pick_reg_value(ANGLE_W, PICK_MIN);
      settings[REG_SCALE_DEV]     = pick_reg_value(ANGLE_W, PICK_MIN);
      settings[REG_INV_SCALE_DEV] = pick_reg_value(ANGLE_W, PICK_MIN);
      load_settings();
      send_point(FORWARD, 34'sd2048, 34'sd2048, '0);
      send_point(FORWARD, -34'sd2048, -34'sd2048, '0);
      send_point(INVERSE, 34'sd2048, -34'sd2048, 34'sd5);
      send_point(INVERSE, -34'sd2048, 34'sd2048, -34'sd5);

      // Every register at its top, then at its bottom.
      settle_block();
      fill_settings(PICK_MAX);
      load_settings();
      send_landmarks();
      settle_block();
      fill_settings(PICK_MIN);
      load_settings();
      send_landmarks();

      // Random phases rotate through the flow-control modes.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle_block();
         fill_settings(-1);
         load_settings();
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 82; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 82; end
            default: begin idle_pct = 24; stall_pct = 24; end
         endcase
         for (int n = 0; n < POINTS_PER_PHASE; n++) begin
            // back-to-back sender meets a long rsp holdoff: the pipe backs up
            if (ph % 4 == 0 && n == 40) hold_request = HOLDOFF_CYCLES;
            send_random_point();
         end
      end

      settle_block();
      if (board.mismatches == 0 && board.pending() == 0)
         $display("helmert_seven_parameter_transform regression: pass");
      else
         $display("helmert_seven_parameter_transform regression: fail");
      $finish;
   end

endmodule
